/* rtl/plbc_pkg.sv */
// ----------------------------------------------------------------------------
// plbc_pkg
// Shared types and constants for the pinned LRU block cache policy.
// ----------------------------------------------------------------------------
package plbc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int TAG_W       = 20;
  localparam int SLOT_W      = 4;
  localparam int DISK_W      = 21;
  localparam int STAMP_W     = 32;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_RANGE  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_PINNED = 2'd3
  } status_t;

  typedef struct packed {
    op_t               opcode;
    logic [TAG_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] chosen_slot;
    logic              hit;
    logic              write_back;
    logic [TAG_W-1:0]  evicted_block;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

/* rtl/plbc_ram.sv */
// ----------------------------------------------------------------------------
// plbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module plbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/plbc_ctrl.sv */
// ----------------------------------------------------------------------------
// plbc_ctrl
// Sequencer for request acceptance, slot scan and commit of the result.
// ----------------------------------------------------------------------------
module plbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plbc_pkg::ctl_sts_t  sts,
  output plbc_pkg::ctl_cmd_t  cmd
);
  import plbc_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // Puts and out-of-range gets need no scan of the slots.
          state_nxt  = sts.need_scan ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/plbc_dpath.sv */
// ----------------------------------------------------------------------------
// plbc_dpath
// Slot store, serial tag match and LRU victim search, state update and the
// result register.
// ----------------------------------------------------------------------------
module plbc_dpath #(
  parameter int ENTRIES = plbc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [plbc_pkg::DISK_W-1:0]   cfg_wr_data,
  input  plbc_pkg::req_t                in_data,
  input  plbc_pkg::ctl_cmd_t            cmd,
  output plbc_pkg::ctl_sts_t            sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output plbc_pkg::rsp_t                out_data
);
  import plbc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int RW = TAG_W + STAMP_W;

  logic [DISK_W-1:0]     disk_blocks_r;
  logic [STAMP_W-1:0]    stamp_cnt_r;
  logic [ENTRIES-1:0]    valid_r;
  logic [ENTRIES-1:0]    pinned_r;
  req_t                  req_r;
  logic                  scan_r;

  logic [IW-1:0]         rd_idx_r;
  logic                  cmp_valid_r;
  logic [IW-1:0]         cmp_idx_r;
  logic                  found_r;
  logic [IW-1:0]         found_idx_r;
  logic                  least_any_r;
  logic [IW-1:0]         least_idx_r;
  logic [STAMP_W-1:0]    least_stamp_r;
  logic [TAG_W-1:0]      least_tag_r;
  logic                  least_valid_r;

  logic                  out_valid_r;
  rsp_t                  out_data_r;

  logic [RW-1:0]         rd_data;
  logic [TAG_W-1:0]      ent_tag;
  logic [STAMP_W-1:0]    ent_stamp;
  logic                  ent_valid;
  logic                  ent_pinned;

  logic [STAMP_W-1:0]    new_stamp;
  logic                  wr_en;
  logic [IW-1:0]         wr_idx;
  logic                  put_en;
  rsp_t                  rsp;

  // Slot contents: tag above stamp. An entry without its valid bit reads as empty.
  plbc_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata ({req_r.block_number, new_stamp}),
    .re    (cmd.scan),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  assign ent_valid  = valid_r[cmp_idx_r];
  assign ent_pinned = pinned_r[cmp_idx_r];
  assign ent_tag    = ent_valid ? rd_data[RW-1:STAMP_W] : '0;
  assign ent_stamp  = ent_valid ? rd_data[STAMP_W-1:0] : '0;

  assign sts.need_scan = (in_data.opcode == OP_GET) &&
                         (DISK_W'(in_data.block_number) < disk_blocks_r);
  assign sts.scan_last = (rd_idx_r == IW'(ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // The stamp counter skips zero, since a zero stamp marks an empty slot.
  always_comb begin
    new_stamp = stamp_cnt_r + STAMP_W'(1);
    if (new_stamp == '0) begin
      new_stamp = STAMP_W'(1);
    end
  end

  always_comb begin
    rsp    = '0;
    wr_en  = 1'b0;
    wr_idx = found_idx_r;
    put_en = 1'b0;
    if (!scan_r) begin
      if (req_r.opcode == OP_PUT) begin
        rsp.chosen_slot = req_r.slot;
        put_en          = 1'b1;
      end else begin
        rsp.status = STAT_RANGE;
      end
    end else if (found_r) begin
      if (pinned_r[found_idx_r]) begin
        rsp.status = STAT_PINNED;
      end else begin
        wr_en           = 1'b1;
        rsp.chosen_slot = SLOT_W'(found_idx_r);
        rsp.hit         = 1'b1;
      end
    end else if (!least_any_r) begin
      rsp.status = STAT_FULL;
    end else begin
      wr_en             = 1'b1;
      wr_idx            = least_idx_r;
      rsp.chosen_slot   = SLOT_W'(least_idx_r);
      rsp.write_back    = least_valid_r;
      rsp.evicted_block = least_valid_r ? least_tag_r : '0;
    end
    wr_en = wr_en && cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_blocks_r <= '0;
      stamp_cnt_r   <= STAMP_W'(1);
      valid_r       <= '0;
      pinned_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        disk_blocks_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        stamp_cnt_r      <= new_stamp;
        valid_r[wr_idx]  <= 1'b1;
        pinned_r[wr_idx] <= 1'b1;
      end
      // A put naming a slot beyond the store is ignored.
      for (int i = 0; i < ENTRIES; i++) begin
        if (cmd.commit && put_en && (32'(req_r.slot) == i)) begin
          pinned_r[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
      least_any_r <= 1'b0;
    end else begin
      cmp_valid_r <= cmd.scan;
      if (cmd.accept) begin
        rd_idx_r    <= '0;
        found_r     <= 1'b0;
        least_any_r <= 1'b0;
      end else if (cmd.scan) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      if (cmp_valid_r) begin
        // The first valid entry with a matching tag is the hit.
        if (!found_r && ent_valid && (ent_tag == req_r.block_number)) begin
          found_r <= 1'b1;
        end
        // Strict compare keeps the lowest index among equal stamps.
        if (!ent_pinned && (!least_any_r || (ent_stamp < least_stamp_r))) begin
          least_any_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
    if (cmd.accept) begin
      req_r  <= in_data;
      scan_r <= sts.need_scan;
    end
    if (cmp_valid_r) begin
      if (!found_r && ent_valid && (ent_tag == req_r.block_number)) begin
        found_idx_r <= cmp_idx_r;
      end
      if (!ent_pinned && (!least_any_r || (ent_stamp < least_stamp_r))) begin
        least_idx_r   <= cmp_idx_r;
        least_stamp_r <= ent_stamp;
        least_tag_r   <= ent_tag;
        least_valid_r <= ent_valid;
      end
    end
    if (cmd.commit) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/pinned_lru_block_cache_policy.sv */
// ----------------------------------------------------------------------------
// pinned_lru_block_cache_policy
// Fully associative block cache replacement policy with pin marks and
// timestamp LRU selection.
// ----------------------------------------------------------------------------
// A get in range scans the slot RAM one slot per cycle, from slot 0 upward,
// then passes a finish state before its result is committed.
// Puts and out-of-range gets skip the scan and go straight to commit.
// One request is taken at a time; a new request is taken in the cycle after
// the previous commit. A stalled output holds the commit back.
// Reset (synchronous, rst_n low) empties and unpins all slots at once.
module pinned_lru_block_cache_policy #(
  parameter int ENTRIES = plbc_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [plbc_pkg::DISK_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  plbc_pkg::req_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output plbc_pkg::rsp_t              out_data
);
  import plbc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  plbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plbc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

/* rtl/plbc_checker.sv */
// ----------------------------------------------------------------------------
// plbc_checker
// Port-level checks for the pinned LRU block cache policy.
// ----------------------------------------------------------------------------
module plbc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input plbc_pkg::rsp_t out_data
);
  import plbc_pkg::*;

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // An error result carries nothing besides its status.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |->
      (out_data.chosen_slot == '0) && !out_data.hit && !out_data.write_back &&
      (out_data.evicted_block == '0))
    else $error("error result with nonzero fields");

  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.write_back &&
      (out_data.evicted_block == '0))
    else $error("hit reports an eviction");

  // Without a write-back there is no evicted block to report.
  a_evict_needs_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_back |-> (out_data.evicted_block == '0))
    else $error("evicted block without write-back");

endmodule

bind pinned_lru_block_cache_policy plbc_checker u_plbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
